// ----- hw/rtl/point_sort_by_origin_distance_assert.svh -----
// Assertion macros used by the point sorter top level.
`ifndef POINT_SORT_BY_ORIGIN_DISTANCE_ASSERT_SVH
`define POINT_SORT_BY_ORIGIN_DISTANCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSOD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psod assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSOD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psod assertion failed");

`endif

// ----- hw/rtl/psod_pkg.sv -----
// Shared constants, types and the sort order for the point sorter.
package psod_pkg;

    localparam int MAX_POINTS = 16;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int COORD_W    = 16;
    localparam int KEY_W      = 2 * COORD_W;

    // One point with its precomputed squared distance.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [KEY_W-1:0]   key;
    } t_point;

    // A point on its way into the cell chain.
    typedef struct packed {
        logic   valid;
        logic   last;
        t_point pt;
    } t_ins;

    // Chain-wide command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    // True when point a sorts strictly before point b.
    function automatic logic goes_before(input t_point a, input t_point b);
        logic res;
        if (a.key != b.key) begin
            res = (a.key < b.key);
        end else if (a.x != b.x) begin
            res = (a.x < b.x);
        end else begin
            res = (a.y > b.y);
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/psod_key.sv -----
// Two-stage squared-distance pipeline in front of the cell chain.
module psod_key
    import psod_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_last,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output t_ins                      o_ins
);

    logic                      r_v1;
    logic                      r_last1;
    logic signed [COORD_W-1:0] r_x1;
    logic signed [COORD_W-1:0] r_y1;
    logic        [KEY_W-1:0]   r_sqx;
    logic        [KEY_W-1:0]   r_sqy;
    logic signed [KEY_W-1:0]   w_sqx;
    logic signed [KEY_W-1:0]   w_sqy;
    logic                      r_v2;
    logic                      r_last2;
    t_point                    r_pt2;

    // Squares of signed values are never negative and fit in 31 bits.
    assign w_sqx = i_x * i_x;
    assign w_sqy = i_y * i_y;

    // Control of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one registers the squares, stage two their sum.
    always_ff @(posedge i_clk) begin
        r_last1   <= i_last;
        r_x1      <= i_x;
        r_y1      <= i_y;
        r_sqx     <= w_sqx;
        r_sqy     <= w_sqy;
        r_last2   <= r_last1;
        r_pt2.x   <= r_x1;
        r_pt2.y   <= r_y1;
        r_pt2.key <= r_sqx + r_sqy;
    end

    assign o_ins = t_ins'{valid: r_v2, last: r_last2, pt: r_pt2};

endmodule

// ----- hw/rtl/psod_cell.sv -----
// One compare-and-shift cell of the sorted point chain.
module psod_cell
    import psod_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_point    i_new,
    input  t_point    i_left,
    input  t_point    i_right,
    input  logic      i_left_before,
    input  logic      i_occ,
    output t_point    o_point,
    output logic      o_before
);

    t_point r_pt;
    t_point n_pt;

    // An empty cell always yields to the arriving point.
    assign o_before = !i_occ || goes_before(i_new, r_pt);

    // Shift takes the right cell; insert the left if it moves, else new.
    always_comb begin
        n_pt = r_pt;
        if (i_ctl.shift) begin
            n_pt = i_right;
        end else if (i_ctl.insert && o_before) begin
            n_pt = i_left_before ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt <= n_pt;
    end

    assign o_point = r_pt;

endmodule

// ----- hw/rtl/point_sort_by_origin_distance.sv -----
// Top level of the point sorter: input pipeline, cell chain and output drain.
// Points stream in at one per cycle while the block is filling; each one
// passes the squared-distance pipeline and is then inserted by a chain of
// MAX_POINTS compare-and-shift cells that keeps the set ordered by squared
// distance, then x ascending, then y descending. Points that arrive with the
// chain full are dropped and flagged on tuser. After the point marked by
// tlast the input stalls while that point reaches the chain, then the held
// points leave one per cycle from the head cell (slower if the sink stalls),
// the final one with tlast; the input reopens as that final result is offered.
module point_sort_by_origin_distance
    import psod_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // point_x [15:0], point_y [31:16]
    input  logic        s_axis_tlast,   // set_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_x [15:0], out_y [31:16]
    output logic        m_axis_tlast,   // out_last
    output logic        m_axis_tuser    // overflowed
);

    `include "point_sort_by_origin_distance_assert.svh"

    typedef enum logic [2:0] {
        ST_FILL  = 3'b001,
        ST_WAIT  = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_drop;
    logic               n_drop;
    logic               r_out_valid;
    logic               r_out_last;
    logic               r_out_drop;
    t_point             r_out_pt;
    logic               w_accept;
    logic               w_load;
    logic               w_full;
    t_ins               w_ins;
    t_cell_ctl          w_ctl;
    t_point             w_cell   [MAX_POINTS];
    logic [MAX_POINTS-1:0] w_before;

    assign s_axis_tready = (r_state == ST_FILL);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    psod_key u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_last  (s_axis_tlast),
        .i_x     (s_axis_tdata[15:0]),
        .i_y     (s_axis_tdata[31:16]),
        .o_ins   (w_ins)
    );

    // Chain commands: insert when a point arrives and room is left, shift on drain.
    assign w_full       = (r_count == CNT_W'(MAX_POINTS));
    assign w_load       = (r_state == ST_DRAIN) && (!r_out_valid || m_axis_tready);
    assign w_ctl.insert = w_ins.valid && !w_full;
    assign w_ctl.shift  = w_load;

    // The cell chain; cell 0 holds the point that sorts first.
    for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
        psod_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_new         (w_ins.pt),
            .i_left        ((gi == 0) ? w_ins.pt : w_cell[(gi == 0) ? 0 : gi - 1]),
            .i_right       ((gi == MAX_POINTS - 1) ? w_ins.pt :
                            w_cell[(gi == MAX_POINTS - 1) ? gi : gi + 1]),
            .i_left_before ((gi == 0) ? 1'b0 : w_before[(gi == 0) ? 0 : gi - 1]),
            .i_occ         (r_count > CNT_W'(gi)),
            .o_point       (w_cell[gi]),
            .o_before      (w_before[gi])
        );
    end

    // Sequencing of fill, wait for the marked point, and drain.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        case (r_state)
            ST_FILL: begin
                if (w_accept && s_axis_tlast) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_ins.valid && w_ins.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_load) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_drop  = 1'b0;
                        n_state = ST_FILL;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
        if (w_ins.valid) begin
            if (w_full) begin
                n_drop = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    // Output register, loaded from the head cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_pt   <= w_cell[0];
            r_out_last <= (r_count == CNT_W'(1));
            r_out_drop <= r_drop;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pt.y, r_out_pt.x};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_drop;

    // The chain never holds more points than it has cells.
    `PSOD_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_POINTS))
    // Draining always has a point to give out.
    `PSOD_ASSERT_IMPL(a_drain_nonempty, r_state == ST_DRAIN, r_count != '0)
    // Loading the final point empties the chain and reopens the input.
    `PSOD_ASSERT_NEXT(a_last_empties, w_load && (r_count == CNT_W'(1)),
                      (r_count == '0) && !r_drop && (r_state == ST_FILL))
    // No point leaves the key pipeline while a set is being drained.
    `PSOD_ASSERT_IMPL(a_no_ins_in_drain, r_state == ST_DRAIN, !w_ins.valid)

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the point sorter: directed and random point sets.
module testbench;
    import psod_pkg::*;

    // One sorted point as it leaves the block.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic                      ovf;
    } t_sorted_out;

    // One row of directed stimulus; typed rows carry their own expectation.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      set_end;
        logic                      typed;
        t_sorted_out               want;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // point_x [15:0], point_y [31:16]
    logic        s_axis_tlast  = 1'b0;  // set_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // out_x [15:0], out_y [31:16]
    logic        m_axis_tlast;          // out_last
    logic        m_axis_tuser;          // overflowed

    // Shadow copy of the sorted store.
    logic signed [COORD_W-1:0] held_x [MAX_POINTS];
    logic signed [COORD_W-1:0] held_y [MAX_POINTS];
    int                        held_n       = 0;
    bit                        held_dropped = 1'b0;

    t_sorted_out sorted_expect_q [$];
    t_stim_row   dir_rows [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int points_sent   = 0;
    int sets_sent     = 0;
    int overflow_sets = 0;
    bit quiet_phase   = 1'b0;

    point_sort_by_origin_distance dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Squared distance from the origin, exact.
    function automatic longint sq_radius(input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y);
        longint lx = x;
        longint ly = y;
        return lx * lx + ly * ly;
    endfunction

    // Sort order: distance ascending, then x ascending, then y descending.
    function automatic bit point_precedes(input logic signed [COORD_W-1:0] ax,
                                          input logic signed [COORD_W-1:0] ay,
                                          input logic signed [COORD_W-1:0] bx,
                                          input logic signed [COORD_W-1:0] by);
        longint da = sq_radius(ax, ay);
        longint db = sq_radius(bx, by);
        if (da != db) begin
            return da < db;
        end
        if (ax != bx) begin
            return ax < bx;
        end
        return ay > by;
    endfunction

    // Insert one accepted point into the shadow store and, at the end of a set,
    // queue the whole sorted run.
    function automatic void sort_in_point(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic set_end,
                                          input bit keep_results);
        int pos;
        int i;
        if (held_n < MAX_POINTS) begin
            pos = held_n;
            for (i = 0; i < held_n; i++) begin
                if (point_precedes(x, y, held_x[i], held_y[i])) begin
                    pos = i;
                    break;
                end
            end
            for (i = held_n; i > pos; i--) begin
                held_x[i] = held_x[i-1];
                held_y[i] = held_y[i-1];
            end
            held_x[pos] = x;
            held_y[pos] = y;
            held_n++;
        end else begin
            held_dropped = 1'b1;
        end
        if (set_end) begin
            if (keep_results) begin
                for (i = 0; i < held_n; i++) begin
                    sorted_expect_q.push_back(t_sorted_out'{x: held_x[i], y: held_y[i],
                        last: (i == held_n - 1), ovf: held_dropped});
                end
            end
            if (held_dropped) begin
                overflow_sets++;
            end
            held_n       = 0;
            held_dropped = 1'b0;
        end
    endfunction

    // Idle length: mostly none or short, sometimes long.
    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (quiet_phase || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    // Random coordinate: full range, small values for ties, or an extreme.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        int r = $urandom_range(0, 99);
        if (r < 50) begin
            return COORD_W'($urandom);
        end
        if (r < 80) begin
            return COORD_W'($urandom_range(0, 12) - 6);
        end
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh8001;
            3: return -16'sd1;
            4: return 16'sd0;
            default: return 16'sd1;
        endcase
    endfunction

    function automatic t_stim_row mk_row(input int x, input int y, input bit set_end,
                                         input bit typed);
        t_stim_row row;
        row.x       = COORD_W'(x);
        row.y       = COORD_W'(y);
        row.set_end = set_end;
        row.typed   = typed;
        row.want    = t_sorted_out'{x: COORD_W'(x), y: COORD_W'(y), last: 1'b1, ovf: 1'b0};
        return row;
    endfunction

    // Present one request and wait until the block takes it.
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic set_end, input bit typed,
                              input t_sorted_out want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= set_end;
        do @(posedge i_clk); while (!s_axis_tready);
        sort_in_point(x, y, set_end, !typed);
        if (typed) begin
            sorted_expect_q.push_back(want);
        end
        points_sent++;
        if (set_end) begin
            sets_sent++;
        end
    endtask

    // Hold the sender off until every queued result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sorted_expect_q.size() != 0);
    endtask

    // Sink side: check each accepted result and pick the next ready value.
    initial begin : sink
        int          stall_left;
        t_sorted_out got;
        t_sorted_out want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_sorted_out'{x: m_axis_tdata[15:0], y: m_axis_tdata[31:16],
                    last: m_axis_tlast, ovf: m_axis_tuser};
                results_seen++;
                if (sorted_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: x=%0d y=%0d last=%0b ovf=%0b",
                            got.x, got.y, got.last, got.ovf);
                    end
                end else begin
                    want = sorted_expect_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
                            got.ovf !== want.ovf) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected x=%0d y=%0d last=%0b ovf=%0b",
                                want.x, want.y, want.last, want.ovf);
                            $display("          got      x=%0d y=%0d last=%0b ovf=%0b",
                                got.x, got.y, got.last, got.ovf);
                        end
                    end
                end
            end
            if (quiet_phase) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < 75) begin
                m_axis_tready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Stimulus: directed rows first, then random point sets.
    initial begin : stimulus
        int          i;
        int          set_len;
        int          k;
        int          r;
        int          random_points;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;

        // Single-point sets whose output is the point itself.
        dir_rows.push_back(mk_row(0, 0, 1, 1));
        dir_rows.push_back(mk_row(-32768, -32768, 1, 1));
        dir_rows.push_back(mk_row(32767, 32767, 1, 1));
        dir_rows.push_back(mk_row(-32768, 32767, 1, 1));
        // Equal distances: ties on x and y, and a duplicate point.
        dir_rows.push_back(mk_row(3, 4, 0, 0));
        dir_rows.push_back(mk_row(3, -4, 0, 0));
        dir_rows.push_back(mk_row(-3, 4, 0, 0));
        dir_rows.push_back(mk_row(4, 3, 0, 0));
        dir_rows.push_back(mk_row(0, -5, 0, 0));
        dir_rows.push_back(mk_row(3, 4, 0, 0));
        dir_rows.push_back(mk_row(-5, 0, 1, 0));
        // Fill the store, then end the set with a point that gets dropped.
        for (i = 0; i < MAX_POINTS; i++) begin
            dir_rows.push_back(mk_row((i - 8) * 37, (i * 13) % 50 - 25, 0, 0));
        end
        dir_rows.push_back(mk_row(1, 1, 1, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].set_end,
                dir_rows[i].typed, dir_rows[i].want);
        end
        drain_results();

        // Random sets: mostly within capacity, some full, some overflowing.
        random_points = 0;
        while (random_points < 200) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                set_len = $urandom_range(1, MAX_POINTS);
            end else if (r < 85) begin
                set_len = MAX_POINTS;
            end else begin
                set_len = MAX_POINTS + $urandom_range(1, 4);
            end
            quiet_phase = ($urandom_range(0, 9) == 0);
            px = pick_coord();
            py = pick_coord();
            for (k = 0; k < set_len; k++) begin
                if (k == 0 || $urandom_range(0, 9) != 0) begin
                    px = pick_coord();
                    py = pick_coord();
                end
                send_point(px, py, k == set_len - 1, 1'b0, '0);
                random_points++;
            end
            if ($urandom_range(0, 7) == 0) begin
                drain_results();
            end
        end
        quiet_phase = 1'b0;
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (sorted_expect_q.size() != 0);
        repeat (MAX_POINTS + 8) @(posedge i_clk);

        $display("Sent %0d points in %0d sets, %0d of them overflowing the store.",
            points_sent, sets_sent, overflow_sets);
        $display("Checked %0d sorted results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog in case the block hangs.
    initial begin : watchdog
        #2000000;
        $display("Timeout with %0d results still outstanding.", sorted_expect_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
